// File: src/zeg_pkg.sv
// Package: widths, register codes and the fractional power-of-two table for zone exposure gain.
`timescale 1ns / 1ps
`default_nettype none

package zeg_pkg;

    localparam int PIX_W     = 16;  // pixel field width on the ports
    localparam int EV_W      = 13;  // one gain register, signed Q4.8
    localparam int EVSUM_W   = 15;  // sum of four gains, signed Q6.8
    localparam int FRAC_W    = 8;
    localparam int EXP_W     = EVSUM_W - FRAC_W;
    localparam int SH_W      = 7;   // shift amount, up to 79
    localparam int POW2_W    = 17;  // Q1.16 table entry
    localparam int POW2_N    = 2 ** FRAC_W;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SKY       = 2'd0,
        CFG_FACE      = 2'd1,
        CFG_SHADOW    = 2'd2,
        CFG_HIGHLIGHT = 2'd3
    } t_cfg_idx;

    typedef logic [POW2_N-1:0][POW2_W-1:0] t_pow2_tbl;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = val;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(f/256) in Q1.16 from a chain of square roots of 2 in Q30
    function automatic t_pow2_tbl build_pow2_tbl();
        logic [8:0][63:0]  roots;
        logic [63:0]       acc;
        logic [FRAC_W-1:0] fb;
        t_pow2_tbl         tbl;
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= 8; k++) begin
            roots[k] = isqrt64(roots[k-1] << 30);
        end
        for (int f = 0; f < POW2_N; f++) begin
            fb  = FRAC_W'(f);
            acc = 64'd1 << 30;
            for (int j = FRAC_W - 1; j >= 0; j--) begin
                if (fb[j]) begin
                    acc = (acc * roots[8-j] + (64'd1 << 29)) >> 30;
                end
            end
            tbl[f] = POW2_W'((acc + (64'd1 << 13)) >> 14);
        end
        return tbl;
    endfunction

    localparam t_pow2_tbl POW2_TBL = build_pow2_tbl();

endpackage

`default_nettype wire

// File: src/zeg_if.sv
// Interfaces: pixel input, pixel output and gain register write channels.
`timescale 1ns / 1ps
`default_nettype none

interface zeg_pix_in_if import zeg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic             in_sky;
    logic             in_face;
    logic             in_shadow;
    logic             in_highlight;

    modport source (
        output valid, red_in, green_in, blue_in, in_sky, in_face, in_shadow, in_highlight,
        input  ready
    );
    modport sink (
        input  valid, red_in, green_in, blue_in, in_sky, in_face, in_shadow, in_highlight,
        output ready
    );
endinterface

interface zeg_pix_out_if import zeg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             clipped;

    modport source (
        output valid, red_out, green_out, blue_out, clipped,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, clipped,
        output ready
    );
endinterface

interface zeg_cfg_if import zeg_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_cfg_idx               idx;
    logic signed [EV_W-1:0] data;

    modport source (
        output valid, idx, data,
        input  ready
    );
    modport sink (
        input  valid, idx, data,
        output ready
    );
endinterface

`default_nettype wire

// File: src/zone_exposure_gain.sv
// Top level: per-zone exposure gain, 2^EV scaling with rounding and saturation.
// Pipeline: 4 register stages (sum, table, multiply, shift).
// One pixel per clock while the output is ready; each stage advances when it is empty or its successor moves.
// Stalls collapse bubbles stage by stage; a full pipeline holds input ready low.
// Reset clears all stage valid bits and sets every zone gain to 0 EV.
// Config writes are taken every cycle and apply to pixels transferred afterwards.
`timescale 1ns / 1ps
`default_nettype none

module zone_exposure_gain import zeg_pkg::*; #(
    parameter int PIXEL_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    zeg_cfg_if.sink        i_cfg,
    zeg_pix_in_if.sink     i_pix,
    zeg_pix_out_if.source  o_pix
);

    localparam int PROD_W = PIXEL_BITS + POW2_W;
    localparam int RND_W  = PROD_W + 1;
    localparam logic [PIXEL_BITS-1:0] MAXV = {PIXEL_BITS{1'b1}};

    // gain registers
    logic signed [EV_W-1:0] r_sky_ev, r_face_ev, r_shadow_ev, r_high_ev;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sky_ev    <= '0;
            r_face_ev   <= '0;
            r_shadow_ev <= '0;
            r_high_ev   <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.idx)
                CFG_SKY:       r_sky_ev    <= i_cfg.data;
                CFG_FACE:      r_face_ev   <= i_cfg.data;
                CFG_SHADOW:    r_shadow_ev <= i_cfg.data;
                CFG_HIGHLIGHT: r_high_ev   <= i_cfg.data;
            endcase
        end
    end

    // stage registers
    logic                                r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic signed [EVSUM_W-1:0]           r_s1_ev;
    logic [2:0][PIXEL_BITS-1:0]          r_s1_px, r_s2_px, r_s4_px;
    logic [POW2_W-1:0]                   r_s2_t;
    logic                                r_s2_left, r_s3_left;
    logic [SH_W-1:0]                     r_s2_sh, r_s3_sh;
    logic [2:0][PROD_W-1:0]              r_s3_prod;
    logic                                r_s4_clip;

    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

    assign s4_rdy      = !r_s4_vld || o_pix.ready;
    assign s3_rdy      = !r_s3_vld || s4_rdy;
    assign s2_rdy      = !r_s2_vld || s3_rdy;
    assign s1_rdy      = !r_s1_vld || s2_rdy;
    assign i_pix.ready = s1_rdy;

    // stage 1: zone gain sum
    logic signed [EVSUM_W-1:0] n_s1_ev;

    always_comb begin
        n_s1_ev = '0;
        if (i_pix.in_sky) begin
            n_s1_ev = n_s1_ev + EVSUM_W'(r_sky_ev);
        end
        if (i_pix.in_face) begin
            n_s1_ev = n_s1_ev + EVSUM_W'(r_face_ev);
        end
        if (i_pix.in_shadow && !i_pix.in_face) begin
            n_s1_ev = n_s1_ev + EVSUM_W'(r_shadow_ev);
        end
        if (i_pix.in_highlight) begin
            n_s1_ev = n_s1_ev + EVSUM_W'(r_high_ev);
        end
    end

    // stage 2: fraction lookup, integer exponent to shift control
    logic signed [EXP_W:0] s2_e;
    logic signed [EXP_W:0] s2_sh;
    logic                  s2_left;

    always_comb begin
        s2_e    = {r_s1_ev[EVSUM_W-1], r_s1_ev[EVSUM_W-1:FRAC_W]};
        s2_left = s2_e >= 8'sd16;
        s2_sh   = s2_left ? (s2_e - 8'sd16) : (8'sd15 - s2_e);
    end

    // stage 3: products
    logic [2:0][PROD_W-1:0] s3_prod;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s3_prod[c] = PROD_W'(r_s2_px[c]) * PROD_W'(r_s2_t);
        end
    end

    // stage 4: shift, round half up, saturate
    logic [2:0][PROD_W-1:0]     s4_shr;
    logic [2:0][RND_W-1:0]      s4_rnd;
    logic [PIXEL_BITS-1:0]      s4_lim;
    logic [2:0][PIXEL_BITS-1:0] s4_val;
    logic [2:0]                 s4_chclip;

    always_comb begin
        s4_lim = MAXV >> r_s3_sh;
        for (int c = 0; c < 3; c++) begin
            s4_shr[c] = r_s3_prod[c] >> r_s3_sh;
            s4_rnd[c] = ({1'b0, s4_shr[c]} + RND_W'(1)) >> 1;
            if (r_s3_left) begin
                s4_chclip[c] = r_s3_prod[c] > PROD_W'(s4_lim);
                s4_val[c]    = PIXEL_BITS'(r_s3_prod[c] << r_s3_sh);
            end else begin
                s4_chclip[c] = s4_rnd[c] > RND_W'(MAXV);
                s4_val[c]    = PIXEL_BITS'(s4_rnd[c]);
            end
            if (s4_chclip[c]) begin
                s4_val[c] = MAXV;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_vld <= i_pix.valid;
            end
            if (s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
            if (s3_rdy) begin
                r_s3_vld <= r_s2_vld;
            end
            if (s4_rdy) begin
                r_s4_vld <= r_s3_vld;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_pix.valid) begin
            r_s1_ev    <= n_s1_ev;
            r_s1_px[0] <= PIXEL_BITS'(i_pix.red_in);
            r_s1_px[1] <= PIXEL_BITS'(i_pix.green_in);
            r_s1_px[2] <= PIXEL_BITS'(i_pix.blue_in);
        end
        if (s2_rdy && r_s1_vld) begin
            r_s2_t    <= POW2_TBL[r_s1_ev[FRAC_W-1:0]];
            r_s2_left <= s2_left;
            r_s2_sh   <= s2_sh[SH_W-1:0];
            r_s2_px   <= r_s1_px;
        end
        if (s3_rdy && r_s2_vld) begin
            r_s3_prod <= s3_prod;
            r_s3_left <= r_s2_left;
            r_s3_sh   <= r_s2_sh;
        end
        if (s4_rdy && r_s3_vld) begin
            r_s4_px   <= s4_val;
            r_s4_clip <= |s4_chclip;
        end
    end

    assign o_pix.valid     = r_s4_vld;
    assign o_pix.red_out   = PIX_W'(r_s4_px[0]);
    assign o_pix.green_out = PIX_W'(r_s4_px[1]);
    assign o_pix.blue_out  = PIX_W'(r_s4_px[2]);
    assign o_pix.clipped   = r_s4_clip;

    // input is refused only when every stage holds a pixel
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_s1_vld && r_s2_vld && r_s3_vld && r_s4_vld))
        else $error("input blocked with a bubble in the pipeline");

    // a product waiting on a stalled output stage is held
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && !s4_rdy) |=> (r_s3_vld && $stable(r_s3_prod)))
        else $error("stage 3 product lost during stall");

    // clip flag implies some channel sits at full scale
    a_clip_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_vld && r_s4_clip) |->
            (r_s4_px[0] == MAXV || r_s4_px[1] == MAXV || r_s4_px[2] == MAXV))
        else $error("clipped set without a saturated channel");

endmodule

`default_nettype wire

// File: test/zeg_checker.sv
// Checker: watches the gain register, pixel input and pixel output channels, predicts and compares.
`timescale 1ns / 1ps

module zeg_checker import zeg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    zeg_cfg_if        i_cfg,
    zeg_pix_in_if     i_pix,
    zeg_pix_out_if    i_res,
    output int        o_err_count,
    output int        o_pending
);

    localparam logic [63:0] PIX_MAX = 64'hFFFF;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             clipped;
    } t_graded_pixel;

    logic [POW2_W-1:0]      frac_gain [POW2_N];
    logic signed [EV_W-1:0] zone_ev [4];
    t_graded_pixel          graded_q [$];
    int                     err_count = 0;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // 2^(f/256), Q1.16, from successive square roots of 2 held in Q30
    initial begin
        logic [63:0] chain [9];
        logic [63:0] acc;
        chain[0] = 64'd1 << 31;
        for (int k = 1; k <= 8; k++) begin
            chain[k] = floor_sqrt(chain[k-1] << 30);
        end
        for (int f = 0; f < POW2_N; f++) begin
            acc = 64'd1 << 30;
            for (int j = 7; j >= 0; j--) begin
                if ((f >> j) & 1) begin
                    acc = (acc * chain[8-j] + (64'd1 << 29)) >> 30;
                end
            end
            frac_gain[f] = POW2_W'((acc + (64'd1 << 13)) >> 14);
        end
    end

    // returns {saturated, value}
    function automatic logic [PIX_W:0] scale_sample(input logic [PIX_W-1:0] px,
                                                    input logic [POW2_W-1:0] mult,
                                                    input int ev_int);
        logic [63:0] prod;
        logic [63:0] val;
        int          rsh;
        prod = 64'(px) * 64'(mult);
        rsh  = 16 - ev_int;
        if (rsh <= 0) begin
            if (prod == 0) begin
                val = '0;
            end else if (-rsh >= 24 || prod > PIX_MAX) begin
                val = '1;
            end else begin
                val = prod << (-rsh);
            end
        end else if (rsh > 41) begin
            val = '0;
        end else begin
            val = (prod + (64'd1 << (rsh - 1))) >> rsh;
        end
        if (val > PIX_MAX) begin
            return {1'b1, {PIX_W{1'b1}}};
        end
        return {1'b0, val[PIX_W-1:0]};
    endfunction

    function automatic t_graded_pixel grade_pixel(input logic [PIX_W-1:0] red,
                                                  input logic [PIX_W-1:0] green,
                                                  input logic [PIX_W-1:0] blue,
                                                  input logic sky, input logic face,
                                                  input logic shadow, input logic highlight);
        int                ev_sum;
        int                ev_int;
        logic [POW2_W-1:0] mult;
        logic [PIX_W:0]    r_s, g_s, b_s;
        t_graded_pixel     res;
        ev_sum = 0;
        if (sky) ev_sum += zone_ev[CFG_SKY];
        if (face) ev_sum += zone_ev[CFG_FACE];
        if (shadow && !face) ev_sum += zone_ev[CFG_SHADOW];
        if (highlight) ev_sum += zone_ev[CFG_HIGHLIGHT];
        ev_int = ((ev_sum + 16384) >> FRAC_W) - 64;
        mult   = frac_gain[(ev_sum + 16384) % POW2_N];
        r_s = scale_sample(red, mult, ev_int);
        g_s = scale_sample(green, mult, ev_int);
        b_s = scale_sample(blue, mult, ev_int);
        res.red     = r_s[PIX_W-1:0];
        res.green   = g_s[PIX_W-1:0];
        res.blue    = b_s[PIX_W-1:0];
        res.clipped = r_s[PIX_W] | g_s[PIX_W] | b_s[PIX_W];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_graded_pixel want;
        t_graded_pixel got;
        if (!i_rst_n) begin
            foreach (zone_ev[i]) zone_ev[i] = '0;
            graded_q.delete();
        end else begin
            // predict before a same-edge register write takes effect
            if (i_pix.valid && i_pix.ready) begin
                want = grade_pixel(i_pix.red_in, i_pix.green_in, i_pix.blue_in,
                                   i_pix.in_sky, i_pix.in_face, i_pix.in_shadow,
                                   i_pix.in_highlight);
                graded_q = {graded_q, want};
            end
            if (i_cfg.valid && i_cfg.ready) begin
                zone_ev[i_cfg.idx] = i_cfg.data;
            end
            if (i_res.valid && i_res.ready) begin
                got = {i_res.red_out, i_res.green_out, i_res.blue_out, i_res.clipped};
                if (graded_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected pixel r=%h g=%h b=%h clip=%b", $time,
                             got.red, got.green, got.blue, got.clipped);
                end else begin
                    want = graded_q.pop_front();
                    if (got !== want) begin
                        err_count++;
                        $display({"%0t: pixel mismatch expected r=%h g=%h b=%h clip=%b",
                                  " got r=%h g=%h b=%h clip=%b"},
                                 $time, want.red, want.green, want.blue, want.clipped,
                                 got.red, got.green, got.blue, got.clipped);
                    end
                end
            end
        end
        o_err_count = err_count;
        o_pending   = graded_q.size();
    end

endmodule

// File: test/zone_exposure_gain_test.sv
// Testbench top: clock, reset, gain and pixel stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module zone_exposure_gain_test;
    import zeg_pkg::*;

    localparam int RST_CYCLES     = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES     = 13;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_PHASE     = 2;

    localparam int FLAG_BIT_SKY   = 0;
    localparam int FLAG_BIT_FACE  = 1;
    localparam int FLAG_BIT_SHAD  = 2;
    localparam int FLAG_BIT_HIGH  = 3;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic pix_taken = 1'b0;
    logic res_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic no_idle   = 1'b0;
    logic hold_req  = 1'b0;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;

    zeg_cfg_if     cfg_bus ();
    zeg_pix_in_if  pix_in_bus ();
    zeg_pix_out_if pix_out_bus ();

    zone_exposure_gain u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_in_bus),
        .o_pix   (pix_out_bus)
    );

    zeg_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_bus),
        .i_pix       (pix_in_bus),
        .i_res       (pix_out_bus),
        .o_err_count (fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        pix_taken <= pix_in_bus.valid && pix_in_bus.ready;
        res_taken <= pix_out_bus.valid && pix_out_bus.ready;
        cfg_taken <= cfg_bus.valid && cfg_bus.ready;
        if ((pix_in_bus.valid && pix_in_bus.ready) || (pix_out_bus.valid && pix_out_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer in %0d cycles", $time, WATCHDOG_LIMIT);
            $display("zone_exposure_gain verification failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle || hold_req) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 35) return PIX_W'($urandom_range(0, 255));
        return PIX_W'($urandom);
    endfunction

    function automatic int pick_gain();
        int r;
        int corner [5];
        corner = '{-4096, 4095, -2048, 2048, 0};
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(0, 1024) - 512;
        if (r < 65) return $urandom_range(0, 4096) - 2048;
        if (r < 80) return corner[$urandom_range(0, 4)];
        return $urandom_range(0, 8191) - 4096;
    endfunction

    // drains the pipeline, then writes all four zone gains back to back
    task automatic program_gains(input int sky, input int face, input int shadow,
                                 input int highlight);
        int vals [4];
        vals = '{sky, face, shadow, highlight};
        pix_in_bus.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        for (int i = 0; i < 4; i++) begin
            cfg_bus.idx  = t_cfg_idx'(i);
            cfg_bus.data = EV_W'(vals[i]);
            do @(negedge i_clk); while (!cfg_taken);
        end
        cfg_bus.valid = 1'b0;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                              input logic [PIX_W-1:0] blue, input logic [3:0] zones);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_in_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_in_bus.red_in       = red;
        pix_in_bus.green_in     = green;
        pix_in_bus.blue_in      = blue;
        pix_in_bus.in_sky       = zones[FLAG_BIT_SKY];
        pix_in_bus.in_face      = zones[FLAG_BIT_FACE];
        pix_in_bus.in_shadow    = zones[FLAG_BIT_SHAD];
        pix_in_bus.in_highlight = zones[FLAG_BIT_HIGH];
        pix_in_bus.valid        = 1'b1;
        do @(negedge i_clk); while (!pix_taken);
    endtask

    initial begin
        int gap;
        pix_out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pix_out_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    pix_out_bus.ready = 1'b1;
                end else begin
                    pix_out_bus.ready = 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        cfg_bus.valid           = 1'b0;
        cfg_bus.idx             = CFG_SKY;
        cfg_bus.data            = '0;
        pix_in_bus.valid        = 1'b0;
        pix_in_bus.red_in       = '0;
        pix_in_bus.green_in     = '0;
        pix_in_bus.blue_in      = '0;
        pix_in_bus.in_sky       = 1'b0;
        pix_in_bus.in_face      = 1'b0;
        pix_in_bus.in_shadow    = 1'b0;
        pix_in_bus.in_highlight = 1'b0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // every zone combination; no zone means unity gain, face masks shadow
        program_gains(256, -300, 77, -2048);
        for (int z = 0; z < 16; z++) begin
            send_pixel(PIX_W'(z * 4099), 16'hFFFF - PIX_W'(z * 777), PIX_W'(z), 4'(z));
        end
        send_pixel('0, '0, '0, 4'hF);
        send_pixel('1, '1, '1, 4'hF);

        // huge gain: nonzero saturates, zero stays zero
        program_gains(4095, 4095, 4095, 4095);
        send_pixel('1, '0, 16'd1, 4'hF);
        send_pixel('0, '0, '0, 4'hD);

        // tiny gain: everything rounds down to zero
        program_gains(-4096, -4096, -4096, -4096);
        send_pixel('1, '1, '1, 4'hF);
        send_pixel(16'd1, 16'd2, 16'd3, 4'h1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            program_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
            no_idle = ($urandom_range(0, 3) == 0);
            if (ph == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_pixel(pick_sample(), pick_sample(), pick_sample(),
                           4'($urandom_range(0, 15)));
            end
        end

        pix_in_bus.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("zone_exposure_gain verification clean");
        end else begin
            $display("zone_exposure_gain verification failed");
        end
        $finish;
    end

endmodule
